// File: hdl/heartbeat_streak_confirmer_macros.svh
// ----------------------------------------------------------------------------
// heartbeat streak confirmer assertion macros
// shared property wrappers, sampled on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_STREAK_CONFIRMER_MACROS_SVH
`define HEARTBEAT_STREAK_CONFIRMER_MACROS_SVH

// same-cycle implication
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// types and constants of the heartbeat streak confirmer
// ----------------------------------------------------------------------------
package hsc_pkg;

   localparam int unsigned DEF_TIME_BITS = 32;
   localparam int unsigned MAX_TIME_BITS = 64;
   localparam int unsigned FIELD_BITS    = 32;
   localparam int unsigned RSP_BITS      = 8;

   localparam logic [MAX_TIME_BITS-1:0] CONFIRM_RESET = 64'd3000;
   localparam logic [MAX_TIME_BITS-1:0] GAP_RESET     = 64'd500;
   localparam logic [MAX_TIME_BITS-1:0] LIMIT_RESET   = 64'd30000;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BEAT  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_POLL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_CONFIRM = 2'd0,
      CSR_GAP     = 2'd1,
      CSR_LIMIT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic config_ok;
      logic timed_out;
      logic confirmed;
      logic session_active;
      logic status;
   } rsp_type;

endpackage

// File: hdl/heartbeat_streak_confirmer.sv
// ----------------------------------------------------------------------------
// heartbeat_streak_confirmer
// one-session heartbeat tracker that confirms a broadcast after a long streak
// ----------------------------------------------------------------------------
// req channel carries one command item: start, heartbeat, reset or poll, with
// a heartbeat stamp and the current time. rsp channel returns one status item
// per command: rejected flag, session active, confirmed, timed out, config ok.
// csr channel writes the confirm duration, gap timeout and session limit; it
// is always ready and should only be used while no item is in flight.
// an item is captured in an input register, evaluated against the session
// state by combinational compares and subtracts, and lands in the result
// register: rsp valid rises once the item has passed the input register and
// the result register, and one item is taken every cycle while rsp is not
// stalled. when rsp is stalled the result register holds, the input register
// still takes one more item, then req_tready drops.
// reset clears the session state, the pipeline valids, and loads the
// default limits 3000, 500 and 30000 ms.
// ----------------------------------------------------------------------------
`include "heartbeat_streak_confirmer_macros.svh"

module heartbeat_streak_confirmer
   import hsc_pkg::*;
#(
   parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*FIELD_BITS-1:0] req_tdata,   // stamp_ms, now_ms
   input  logic [1:0]            req_tuser,     // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_BITS-1:0]   rsp_tdata,     // status, session_active,
                                                // confirmed, timed_out,
                                                // config_ok, zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [FIELD_BITS-1:0] csr_wdata
);

   localparam int unsigned PAD_BITS = MAX_TIME_BITS - FIELD_BITS;
   localparam int unsigned RSP_PAD  = RSP_BITS - $bits(rsp_type);

   logic [MAX_TIME_BITS-1:0] stamp_wide, now_wide, csr_wide;

   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [TIME_BITS-1:0] in_stamp_ff, in_now_ff;

   logic [TIME_BITS-1:0] confirm_ms_ff, gap_ms_ff, limit_ms_ff;

   logic [TIME_BITS-1:0] session_begin_ff, session_begin_in;
   logic [TIME_BITS-1:0] streak_begin_ff, streak_begin_in;
   logic [TIME_BITS-1:0] last_beat_ff, last_beat_in;
   logic                 running_ff, running_in;
   logic                 confirmed_ff, confirmed_in;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 advance, cfg_ok, reject, beat_ok;
   logic [TIME_BITS-1:0] gap_len, new_streak, streak_len, session_len;

   assign stamp_wide = {{PAD_BITS{1'b0}}, req_tdata[FIELD_BITS-1:0]};
   assign now_wide   = {{PAD_BITS{1'b0}}, req_tdata[2*FIELD_BITS-1:FIELD_BITS]};
   assign csr_wide   = {{PAD_BITS{1'b0}}, csr_wdata};

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_ff};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff   <= cmd_type'(req_tuser);
         in_stamp_ff <= stamp_wide[TIME_BITS-1:0];
         in_now_ff   <= now_wide[TIME_BITS-1:0];
      end
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ms_ff <= CONFIRM_RESET[TIME_BITS-1:0];
         gap_ms_ff     <= GAP_RESET[TIME_BITS-1:0];
         limit_ms_ff   <= LIMIT_RESET[TIME_BITS-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CONFIRM: confirm_ms_ff <= csr_wide[TIME_BITS-1:0];
            CSR_GAP:     gap_ms_ff     <= csr_wide[TIME_BITS-1:0];
            CSR_LIMIT:   limit_ms_ff   <= csr_wide[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg_ok = (confirm_ms_ff != '0) && (gap_ms_ff != '0) && (limit_ms_ff != '0)
                   && (gap_ms_ff < confirm_ms_ff) && (confirm_ms_ff < limit_ms_ff);

   assign beat_ok = cfg_ok && running_ff && (in_stamp_ff != '0)
                    && (in_stamp_ff <= in_now_ff)
                    && ((last_beat_ff == '0) || (in_stamp_ff >= last_beat_ff));

   assign gap_len    = in_stamp_ff - last_beat_ff;
   assign new_streak = ((last_beat_ff == '0) || (gap_len > gap_ms_ff))
                       ? in_stamp_ff : streak_begin_ff;
   assign streak_len = in_stamp_ff - new_streak;

   // session update for the item in the input register
   always_comb begin
      session_begin_in = session_begin_ff;
      streak_begin_in  = streak_begin_ff;
      last_beat_in     = last_beat_ff;
      running_in       = running_ff;
      confirmed_in     = confirmed_ff;
      reject           = 1'b0;
      case (in_cmd_ff)
         CMD_START: begin
            if (!cfg_ok || (in_now_ff == '0)) begin
               reject = 1'b1;
            end else begin
               session_begin_in = in_now_ff;
               streak_begin_in  = '0;
               last_beat_in     = '0;
               running_in       = 1'b1;
               confirmed_in     = 1'b0;
            end
         end
         CMD_BEAT: begin
            if (!beat_ok) begin
               reject = 1'b1;
            end else begin
               streak_begin_in = new_streak;
               last_beat_in    = in_stamp_ff;
               if (streak_len >= confirm_ms_ff) begin
                  confirmed_in = 1'b1;
               end
            end
         end
         CMD_RESET: begin
            session_begin_in = '0;
            streak_begin_in  = '0;
            last_beat_in     = '0;
            running_in       = 1'b0;
            confirmed_in     = 1'b0;
         end
         default: ;
      endcase
   end

   assign session_len = in_now_ff - session_begin_in;

   always_comb begin
      rsp_in.status         = reject;
      rsp_in.session_active = running_in;
      rsp_in.confirmed      = confirmed_in;
      rsp_in.timed_out      = running_in && (in_now_ff >= session_begin_in)
                              && (session_len >= limit_ms_ff);
      rsp_in.config_ok      = cfg_ok;
   end

   // session state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         session_begin_ff <= '0;
         streak_begin_ff  <= '0;
         last_beat_ff     <= '0;
         running_ff       <= 1'b0;
         confirmed_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            session_begin_ff <= session_begin_in;
            streak_begin_ff  <= streak_begin_in;
            last_beat_ff     <= last_beat_in;
            running_ff       <= running_in;
            confirmed_ff     <= confirmed_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `HSC_ASSERT_NOW(a_confirm_needs_session, rsp_valid_ff && rsp_ff.confirmed,
      rsp_ff.session_active, "confirmed reported without an active session")
   `HSC_ASSERT_NOW(a_timeout_needs_session, rsp_valid_ff && rsp_ff.timed_out,
      rsp_ff.session_active, "timed out reported without an active session")
   `HSC_ASSERT_NEXT(a_reset_cmd_clears, advance && (in_cmd_ff == CMD_RESET),
      !running_ff && !confirmed_ff && (last_beat_ff == '0), "reset command left state")
   `HSC_ASSERT_NEXT(a_state_holds_when_idle, !advance,
      $stable(confirmed_ff) && $stable(running_ff) && $stable(last_beat_ff),
      "session state changed without an item")
   `HSC_ASSERT_NEXT(a_beat_monotonic, advance && (in_cmd_ff == CMD_BEAT) && beat_ok,
      last_beat_ff >= $past(last_beat_ff), "accepted heartbeat moved last beat back")

endmodule
